FILE: hdl/assert_macros.svh
// Assertion macros shared by the face filter controller and datapath.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SPFF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define SPFF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SPFF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/spff_pkg.sv
// Shared widths, codes and controller/datapath interface types for the
// polygon face filter. No dependencies.
package spff_pkg;

	localparam int MAX_FACE_VERTS_DEF = 8;
	localparam int MIN_FACE_VERTS     = 3;

	localparam int IDX_W     = 24;
	localparam int POS_W     = 16;
	localparam int MA_W      = 20;
	localparam int VC_W      = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 1;
	localparam int REASON_W  = 3;
	localparam int FV_W      = 4;
	localparam int DIFF_W    = POS_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int TERM_W    = PROD_W + 1;
	localparam int CROSS_W   = 40;
	localparam int MAG_W     = 21;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int MA2_W     = 2 * MA_W;
	localparam int SUM_W     = SQ_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b1;

	localparam logic [REASON_W-1:0] RSN_KEPT      = 3'd0;
	localparam logic [REASON_W-1:0] RSN_BOUNDS    = 3'd1;
	localparam logic [REASON_W-1:0] RSN_TOO_FEW   = 3'd2;
	localparam logic [REASON_W-1:0] RSN_DUPLICATE = 3'd3;
	localparam logic [REASON_W-1:0] RSN_SMALL     = 3'd4;
	localparam logic [REASON_W-1:0] RSN_TOO_LONG  = 3'd5;

	typedef struct packed {
		logic cap;
		logic mul;
		logic acc;
		logic mag;
		logic sq;
		logic sum;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic last;
	} stat_t;

endpackage

FILE: hdl/spff_ctrl.sv
// Sequencing state machine of the face filter: handshakes and datapath commands.
// Depends on spff_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spff_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  spff_pkg::stat_t stat,
	output spff_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_MAG,
		S_SQ,
		S_SUM,
		S_VERD
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		cmd.cap  = (state_q == S_IDLE) && in_valid && in_ready_q;
		cmd.mul  = (state_q == S_MUL);
		cmd.acc  = (state_q == S_ACC);
		cmd.mag  = (state_q == S_MAG);
		cmd.sq   = (state_q == S_SQ);
		cmd.sum  = (state_q == S_SUM);
		cmd.load = (state_q == S_VERD) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !cmd.load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_MUL;
						in_ready_q <= 1'b0;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (stat.last) begin
						state_q <= S_MAG;
					end else begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_MAG: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_VERD;
				end
				S_VERD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	`SPFF_ASSERT_NOW(a_ready_only_idle, in_ready_q, state_q == S_IDLE, "ready outside idle")
	`SPFF_ASSERT_NOW(a_load_slot_free, cmd.load, !out_valid_q || out_ready, "result overwritten")
	`SPFF_ASSERT_NEXT(a_cap_starts_mul, cmd.cap, state_q == S_MUL && !in_ready_q, "capture lost")

endmodule

FILE: hdl/spff_dp.sv
// Datapath of the face filter: configuration, index store, fan cross-product
// accumulation, squared-length test and verdict register. Depends on spff_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spff_dp #(
	parameter int MAX_FACE_VERTS = spff_pkg::MAX_FACE_VERTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  spff_pkg::cmd_t                       cmd,
	output spff_pkg::stat_t                      stat,
	input  logic                                 cfg_we,
	input  logic [spff_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spff_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic [spff_pkg::IDX_W-1:0]           vertex_index,
	input  logic signed [spff_pkg::POS_W-1:0]    pos_x,
	input  logic signed [spff_pkg::POS_W-1:0]    pos_y,
	input  logic signed [spff_pkg::POS_W-1:0]    pos_z,
	input  logic                                 last_vertex,
	output logic                                 keep_face,
	output logic [spff_pkg::REASON_W-1:0]        drop_reason,
	output logic [spff_pkg::FV_W-1:0]            face_vertices
);

	localparam int CNT_W = $clog2(MAX_FACE_VERTS + 2);
	localparam int SEL_W = $clog2(MAX_FACE_VERTS);
	localparam int DW    = spff_pkg::DIFF_W;
	localparam int PW    = spff_pkg::PROD_W;
	localparam int TW    = spff_pkg::TERM_W;
	localparam int CW    = spff_pkg::CROSS_W;
	localparam int MW    = spff_pkg::MAG_W;
	localparam int QW    = spff_pkg::SQ_W;
	localparam int M2W   = spff_pkg::MA2_W;
	localparam int SW    = spff_pkg::SUM_W;
	localparam int FW    = spff_pkg::FV_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FACE_VERTS);
	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(spff_pkg::MIN_FACE_VERTS);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

	logic [spff_pkg::MA_W-1:0]  min_area_q;
	logic [spff_pkg::VC_W-1:0]  vertex_count_q;

	logic [spff_pkg::IDX_W-1:0] seen_q [MAX_FACE_VERTS];
	logic signed [spff_pkg::POS_W-1:0] first_q [3];
	logic signed [spff_pkg::POS_W-1:0] prev_q [3];
	logic signed [spff_pkg::POS_W-1:0] pos [3];

	logic [CNT_W-1:0] cnt_q;
	logic             bounds_q;
	logic             dup_q;
	logic             dup_hit;

	logic             last_s1;
	logic             acc_en_s1;
	logic signed [DW-1:0] a_s1 [3];
	logic signed [DW-1:0] b_s1 [3];
	logic signed [PW-1:0] ax [3];
	logic signed [PW-1:0] bx [3];
	logic signed [PW-1:0] prod_s2 [6];
	logic signed [TW-1:0] term [3];
	logic signed [CW-1:0] cross_q [3];
	logic        [CW-1:0] abs_c [3];
	logic        [MW-1:0] mag_s3 [3];
	logic                 big_s3;
	logic        [QW-1:0] sq_s4 [3];
	logic        [M2W-1:0] ma2_s4;
	logic                 big_s4;
	logic        [SW-1:0] len_sum;
	logic        [SW-1:0] thr;
	logic                 small_s5;

	logic                             keep_q;
	logic [spff_pkg::REASON_W-1:0]    reason_q;
	logic [FW-1:0]                    fv_q;
	logic [spff_pkg::REASON_W-1:0]    reason;

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q     <= '0;
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spff_pkg::REG_MIN_AREA:     min_area_q     <= cfg_wdata[spff_pkg::MA_W-1:0];
				spff_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_wdata[spff_pkg::VC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dup_hit = 1'b0;
		for (int i = 0; i < MAX_FACE_VERTS; i++) begin
			if (CNT_W'(i) < cnt_q && seen_q[i] == vertex_index) begin
				dup_hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap && cnt_q < CNT_MAX) begin
			seen_q[cnt_q[SEL_W-1:0]] <= vertex_index;
		end
	end

	// capture stage: position differences from the fan origin
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= DW'(prev_q[k]) - DW'(first_q[k]);
				b_s1[k] <= DW'(pos[k]) - DW'(first_q[k]);
			end
			if (cnt_q < CNT_MAX) begin
				if (cnt_q == '0) begin
					for (int k = 0; k < 3; k++) begin
						first_q[k] <= pos[k];
					end
				end
				for (int k = 0; k < 3; k++) begin
					prev_q[k] <= pos[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			bounds_q  <= 1'b0;
			dup_q     <= 1'b0;
			last_s1   <= 1'b0;
			acc_en_s1 <= 1'b0;
		end else if (cmd.load) begin
			cnt_q    <= '0;
			bounds_q <= 1'b0;
			dup_q    <= 1'b0;
		end else if (cmd.cap) begin
			if (vertex_index >= vertex_count_q) begin
				bounds_q <= 1'b1;
			end
			if (dup_hit) begin
				dup_q <= 1'b1;
			end
			if (cnt_q <= CNT_MAX) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			last_s1   <= last_vertex;
			acc_en_s1 <= (cnt_q >= CNT_TWO) && (cnt_q < CNT_MAX);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ax[k] = PW'(a_s1[k]);
			bx[k] = PW'(b_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2[0] <= ax[1] * bx[2];
			prod_s2[1] <= ax[2] * bx[1];
			prod_s2[2] <= ax[2] * bx[0];
			prod_s2[3] <= ax[0] * bx[2];
			prod_s2[4] <= ax[0] * bx[1];
			prod_s2[5] <= ax[1] * bx[0];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			term[k] = TW'(prod_s2[2 * k]) - TW'(prod_s2[2 * k + 1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cross_q[k] <= '0;
			end
		end else if (cmd.load) begin
			for (int k = 0; k < 3; k++) begin
				cross_q[k] <= '0;
			end
		end else if (cmd.acc && acc_en_s1) begin
			for (int k = 0; k < 3; k++) begin
				cross_q[k] <= cross_q[k] + CW'(term[k]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			abs_c[k] = cross_q[k][CW-1] ? CW'(-cross_q[k]) : CW'(cross_q[k]);
		end
	end

	// squared length of the cross vector against four times min_area squared
	always_ff @(posedge clk) begin
		if (cmd.mag) begin
			big_s3 <= (|abs_c[0][CW-1:MW]) || (|abs_c[1][CW-1:MW]) ||
				(|abs_c[2][CW-1:MW]);
			for (int k = 0; k < 3; k++) begin
				mag_s3[k] <= abs_c[k][MW-1:0];
			end
		end
		if (cmd.sq) begin
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= QW'(mag_s3[k]) * QW'(mag_s3[k]);
			end
			ma2_s4 <= M2W'(min_area_q) * M2W'(min_area_q);
			big_s4 <= big_s3;
		end
		if (cmd.sum) begin
			small_s5 <= !big_s4 && (len_sum < thr);
		end
	end

	assign len_sum = SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
	assign thr     = SW'({ma2_s4, 2'b00});

	always_comb begin
		if (min_area_q == '0) begin
			reason = spff_pkg::RSN_KEPT;
		end else if (bounds_q) begin
			reason = spff_pkg::RSN_BOUNDS;
		end else if (cnt_q > CNT_MAX) begin
			reason = spff_pkg::RSN_TOO_LONG;
		end else if (cnt_q < CNT_MIN) begin
			reason = spff_pkg::RSN_TOO_FEW;
		end else if (dup_q) begin
			reason = spff_pkg::RSN_DUPLICATE;
		end else if (small_s5) begin
			reason = spff_pkg::RSN_SMALL;
		end else begin
			reason = spff_pkg::RSN_KEPT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			keep_q   <= (reason == spff_pkg::RSN_KEPT);
			reason_q <= reason;
			fv_q     <= FW'(cnt_q);
		end
	end

	assign stat.last     = last_s1;
	assign keep_face     = keep_q;
	assign drop_reason   = reason_q;
	assign face_vertices = fv_q;

	`SPFF_ASSERT(a_cnt_saturates, cnt_q <= CNT_MAX + CNT_W'(1), "vertex count past saturation")
	`SPFF_ASSERT_NEXT(a_load_clears, cmd.load, cnt_q == '0 && !bounds_q && !dup_q, "face not cleared")
	`SPFF_ASSERT_NOW(a_load_after_last, cmd.load, last_s1, "verdict without last vertex")

endmodule

FILE: hdl/small_polygon_face_filter_core.sv
// Top level of the polygon face filter: controller and datapath.
// Depends on spff_pkg, spff_ctrl and spff_dp.

// Each vertex passes through the capture, multiply and accumulate steps of
// the fan cross product; the last vertex of a face adds the magnitude, square,
// sum-and-compare and verdict steps, and waits in the verdict step while the
// previous verdict still sits unread in the output register. The next face
// can begin while a verdict waits to be taken. Faults for a face are reported
// in the order bounds, too long, too few, duplicate, small area; min_area of
// zero keeps every face.
module small_polygon_face_filter_core #(
	parameter int MAX_FACE_VERTS = spff_pkg::MAX_FACE_VERTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [spff_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spff_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [spff_pkg::IDX_W-1:0]           vertex_index,
	input  logic signed [spff_pkg::POS_W-1:0]    pos_x,
	input  logic signed [spff_pkg::POS_W-1:0]    pos_y,
	input  logic signed [spff_pkg::POS_W-1:0]    pos_z,
	input  logic                                 last_vertex,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 keep_face,
	output logic [spff_pkg::REASON_W-1:0]        drop_reason,
	output logic [spff_pkg::FV_W-1:0]            face_vertices
);

	spff_pkg::cmd_t  cmd;
	spff_pkg::stat_t stat;

	spff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spff_dp #(
		.MAX_FACE_VERTS (MAX_FACE_VERTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.vertex_index  (vertex_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.last_vertex   (last_vertex),
		.keep_face     (keep_face),
		.drop_reason   (drop_reason),
		.face_vertices (face_vertices)
	);

endmodule
